// File: rtl/icf_pkg.sv
// Shared types, constants and functions for the IMU complementary filter.
package icf_pkg;

    localparam int TAB_LEN = 24;
    localparam int ZW      = 34;   // CORDIC angle accumulator, 2^-32 turn units
    localparam int XYW     = 27;   // CORDIC vector registers

    typedef logic signed [ZW-1:0]  t_zacc;
    typedef logic signed [XYW-1:0] t_vec;

    typedef enum logic [1:0] {
        REG_GYRO_GAIN = 2'd0,
        REG_KEEP      = 2'd1,
        REG_MAG_LOW   = 2'd2,
        REG_MAG_HIGH  = 2'd3
    } t_reg_idx;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_INTEG,
        ST_CORDIC,
        ST_SCALE,
        ST_BLEND,
        ST_OUT
    } t_state;

    // Command from the sequencer to the lanes.
    typedef struct packed {
        logic load;
        logic step;
    } t_lane_ctl;

    // atan(2^-i) in 2^-32 turn units.
    function automatic logic [29:0] atan_turn(input logic [4:0] idx);
        case (idx)
            5'd0:  atan_turn = 30'd536870912;
            5'd1:  atan_turn = 30'd316933406;
            5'd2:  atan_turn = 30'd167458907;
            5'd3:  atan_turn = 30'd85004756;
            5'd4:  atan_turn = 30'd42667331;
            5'd5:  atan_turn = 30'd21354465;
            5'd6:  atan_turn = 30'd10679838;
            5'd7:  atan_turn = 30'd5340245;
            5'd8:  atan_turn = 30'd2670163;
            5'd9:  atan_turn = 30'd1335087;
            5'd10: atan_turn = 30'd667544;
            5'd11: atan_turn = 30'd333772;
            5'd12: atan_turn = 30'd166886;
            5'd13: atan_turn = 30'd83443;
            5'd14: atan_turn = 30'd41722;
            5'd15: atan_turn = 30'd20861;
            5'd16: atan_turn = 30'd10430;
            5'd17: atan_turn = 30'd5215;
            5'd18: atan_turn = 30'd2608;
            5'd19: atan_turn = 30'd1304;
            5'd20: atan_turn = 30'd652;
            5'd21: atan_turn = 30'd326;
            5'd22: atan_turn = 30'd163;
            5'd23: atan_turn = 30'd81;
            default: atan_turn = 30'd0;
        endcase
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [49:0] v);
        if (v > 50'sd2147483647)       sat32 = 32'sh7fffffff;
        else if (v < -50'sd2147483648) sat32 = 32'sh80000000;
        else                           sat32 = v[31:0];
    endfunction

endpackage

// File: rtl/icf_cordic_lane.sv
// One vectoring CORDIC lane for atan2(y, x); one micro-rotation per cycle while step is set.
module icf_cordic_lane
    import icf_pkg::*;
(
    input  logic               i_clk,
    input  t_lane_ctl          i_ctl,
    input  logic [4:0]         i_iter,
    input  logic signed [15:0] i_y,
    input  logic signed [15:0] i_x,
    output t_zacc              o_z,
    output logic               o_zero
);

    t_vec  r_x, r_y;
    t_zacc r_z;
    logic  r_zero;
    t_vec  sx, sy;
    logic signed [16:0] xe, ye;

    assign xe = 17'(i_x);
    assign ye = 17'(i_y);
    assign sx = r_x >>> i_iter;
    assign sy = r_y >>> i_iter;

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_zero <= (i_x == 16'sd0) && (i_y == 16'sd0);
            // fold left half-plane by a half turn
            if (i_x < 0) begin
                r_z <= (i_y >= 0) ? t_zacc'(64'sh80000000) : -t_zacc'(64'sh80000000);
                r_x <= t_vec'(-xe) <<< 8;
                r_y <= t_vec'(-ye) <<< 8;
            end else begin
                r_z <= '0;
                r_x <= t_vec'(xe) <<< 8;
                r_y <= t_vec'(ye) <<< 8;
            end
        end else if (i_ctl.step) begin
            if (r_y > 0) begin
                r_x <= r_x + sy;
                r_y <= r_y - sx;
                r_z <= r_z + t_zacc'(atan_turn(i_iter));
            end else begin
                r_x <= r_x - sy;
                r_y <= r_y + sx;
                r_z <= r_z - t_zacc'(atan_turn(i_iter));
            end
        end
    end

    assign o_z    = r_z;
    assign o_zero = r_zero;

endmodule

// File: rtl/icf_merge.sv
// Per-axis angle update: gyro integration, turn-to-degree scaling and blend.
module icf_merge
    import icf_pkg::*;
#(
    parameter int ANGLE_FRAC_BITS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_state             i_state,
    input  logic signed [15:0] i_gyro,
    input  logic [23:0]        i_gain,
    input  logic [16:0]        i_keep,
    input  t_zacc              i_z,
    input  logic               i_zero,
    output logic signed [31:0] o_angle
);

    localparam int SH = 32 - ANGLE_FRAC_BITS;

    logic signed [31:0] r_angle;
    logic signed [41:0] r_acc;   // accelerometer angle in angle LSBs
    logic signed [41:0] prod_g;
    logic signed [49:0] sum_i;
    logic signed [43:0] zdeg;
    logic signed [49:0] bsum;
    logic signed [49:0] bsh;
    logic signed [17:0] wk, wa;
    logic signed [41:0] n_acc;

    assign prod_g = 42'(i_gyro) * $signed({1'b0, i_gain});
    assign sum_i  = 50'(r_angle) + 50'(prod_g >>> SH);
    assign zdeg   = 44'(i_z) * 44'sd360 + (44'sd1 <<< (SH - 1));
    assign n_acc  = i_zero ? 42'sd0 : 42'(zdeg >>> SH);
    assign wk     = {1'b0, i_keep};
    assign wa     = 18'sd65536 - wk;
    assign bsum   = 50'(r_angle) * 50'(wk) + 50'(r_acc) * 50'(wa) + 50'sd32768;
    assign bsh    = bsum >>> 16;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_angle <= '0;
        end else if (i_state == ST_INTEG) begin
            r_angle <= sat32(sum_i);
        end else if (i_state == ST_BLEND) begin
            r_angle <= sat32(bsh);
        end
        if (i_state == ST_SCALE) r_acc <= n_acc;
    end

    assign o_angle = r_angle;

endmodule

// File: rtl/imu_complementary_filter.sv
// After an input transfer, ST_OUT (result valid) follows ST_INTEG, ST_CORDIC, ST_SCALE and
// ST_BLEND when the accelerometer blend applies, and ST_INTEG alone when it does not.
// One sample at a time: s_axis_tready is high only in ST_IDLE, after the result is taken;
// the three atan2 lanes run one micro-rotation each per cycle while in ST_CORDIC.
// Reset: synchronous active low; clears angles to zero and registers to their
// defaults (gain 65536, keep 64225, window 8192..32768).
module imu_complementary_filter
    import icf_pkg::*;
#(
    parameter int CORDIC_STEPS    = 16,
    parameter int ANGLE_FRAC_BITS = 16
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          s_axis_tvalid,
    output logic          s_axis_tready,
    input  logic [95:0]   s_axis_tdata,  // accel_x, accel_y, accel_z, gyro_x, gyro_y, gyro_z
    output logic          m_axis_tvalid,
    input  logic          m_axis_tready,
    output logic [103:0]  m_axis_tdata,  // pitch, roll, yaw, accel_applied, 7 zero bits
    input  logic          i_cfg_we,
    input  logic [1:0]    i_cfg_idx,
    input  logic [23:0]   i_cfg_data
);

    localparam int STEPS = (CORDIC_STEPS < TAB_LEN) ? CORDIC_STEPS : TAB_LEN;

    t_state r_state, n_state;
    logic [4:0]  r_iter;
    logic [23:0] r_gain;
    logic [16:0] r_keep, r_low, r_high;
    logic [95:0] r_in;
    logic        r_apply;
    t_lane_ctl   ctl;
    logic signed [15:0] ax, ay, az;
    logic [17:0] mag;
    logic        in_window;
    logic [16:0] keep_sat;
    t_zacc z_p, z_r, z_y;
    logic  zz_p, zz_r, zz_y;
    logic signed [31:0] a_p, a_r, a_y;
    t_state merge_st;

    assign ax = r_in[15:0];
    assign ay = r_in[31:16];
    assign az = r_in[47:32];
    assign mag = 18'(ax < 0 ? -17'(ax) : 17'(ax)) + 18'(ay < 0 ? -17'(ay) : 17'(ay))
               + 18'(az < 0 ? -17'(az) : 17'(az));
    assign in_window = (mag > 18'(r_low)) && (mag < 18'(r_high));
    assign keep_sat = (r_keep > 17'd65536) ? 17'd65536 : r_keep;

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE:   if (s_axis_tvalid) n_state = ST_INTEG;
            ST_INTEG:  n_state = in_window ? ST_CORDIC : ST_OUT;
            ST_CORDIC: if (r_iter == 5'(STEPS - 1)) n_state = ST_SCALE;
            ST_SCALE:  n_state = ST_BLEND;
            ST_BLEND:  n_state = ST_OUT;
            ST_OUT:    if (m_axis_tready) n_state = ST_IDLE;
            default:   n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        s_axis_tready = (r_state == ST_IDLE);
        m_axis_tvalid = (r_state == ST_OUT);
        ctl.load      = (r_state == ST_INTEG);
        ctl.step      = (r_state == ST_CORDIC);
        merge_st      = (r_state == ST_BLEND && !r_apply) ? ST_IDLE : r_state;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_iter  <= '0;
            r_apply <= 1'b0;
            r_gain  <= 24'd65536;
            r_keep  <= 17'd64225;
            r_low   <= 17'd8192;
            r_high  <= 17'd32768;
        end else begin
            r_state <= n_state;
            if (r_state == ST_CORDIC) r_iter <= r_iter + 5'd1;
            else                      r_iter <= '0;
            if (r_state == ST_IDLE && s_axis_tvalid) begin
                r_in <= s_axis_tdata;
            end
            if (r_state == ST_INTEG || r_state == ST_IDLE) begin
                r_apply <= (r_state == ST_INTEG) && in_window;
            end
            if (i_cfg_we) begin
                case (t_reg_idx'(i_cfg_idx))
                    REG_GYRO_GAIN: r_gain <= i_cfg_data;
                    REG_KEEP:      r_keep <= i_cfg_data[16:0];
                    REG_MAG_LOW:   r_low  <= i_cfg_data[16:0];
                    REG_MAG_HIGH:  r_high <= i_cfg_data[16:0];
                    default: ;
                endcase
            end
        end
    end

    icf_cordic_lane u_lane_p (.i_clk, .i_ctl(ctl), .i_iter(r_iter), .i_y(ay), .i_x(az),
                              .o_z(z_p), .o_zero(zz_p));
    icf_cordic_lane u_lane_r (.i_clk, .i_ctl(ctl), .i_iter(r_iter), .i_y(ax), .i_x(az),
                              .o_z(z_r), .o_zero(zz_r));
    icf_cordic_lane u_lane_y (.i_clk, .i_ctl(ctl), .i_iter(r_iter), .i_y(az), .i_x(ax),
                              .o_z(z_y), .o_zero(zz_y));

    icf_merge #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)) u_merge_p (
        .i_clk, .i_rst_n, .i_state(merge_st), .i_gyro(r_in[63:48]), .i_gain(r_gain),
        .i_keep(keep_sat), .i_z(z_p), .i_zero(zz_p), .o_angle(a_p));
    icf_merge #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)) u_merge_r (
        .i_clk, .i_rst_n, .i_state(merge_st), .i_gyro(r_in[79:64]), .i_gain(r_gain),
        .i_keep(keep_sat), .i_z(z_r), .i_zero(zz_r), .o_angle(a_r));
    icf_merge #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)) u_merge_y (
        .i_clk, .i_rst_n, .i_state(merge_st), .i_gyro(r_in[95:80]), .i_gain(r_gain),
        .i_keep(keep_sat), .i_z(z_y), .i_zero(zz_y), .o_angle(a_y));

    assign m_axis_tdata = {7'd0, r_apply, a_y, a_r, a_p};

endmodule
